### sv/dtq_pkg.sv
`default_nettype none
package dtq_pkg;

    localparam int DTQ_DEPTH = 16;
    localparam int MAX_CAP   = 16;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_SCHED = 2'd0,
        MODE_POLL  = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_SCHED   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_ms;
        logic [31:0] defer_ms;
        logic [15:0] task_id;
        logic [31:0] poll_budget_ms;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] out_task_id;
        logic [31:0] delay_ms;
        logic        flag;
        logic        rejected;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [31:0] sequence_no;
        logic [15:0] task_id;
    } entry_t;

endpackage
`default_nettype wire

### sv/dtq_stream_if.sv
`default_nettype none
interface dtq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### sv/dtq_ram.sv
`default_nettype none
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

### sv/deadline_task_queue.sv
// channel | dir | word      | accepted when
// req     | in  | in_word_t | req.valid && req.ready
// rsp     | out | out_word_t| rsp.valid && rsp.ready
// cfg     | in  | max_release | cfg_we high
//
// schedule: accept, scan of all depth entries via the registered ram read, decide, emit.
// poll: every released task needs a fresh scan; a summary word follows the released ones.
// stop and unused mode finish in the accept cycle. a stalled rsp holds the fsm in emit;
// req is ready only while idle. rsp_valid and valid bits clear on reset, ram is not cleared.
`default_nettype none
module deadline_task_queue
    import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = dtq_pkg::DTQ_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dtq_stream_if.sink   req,
    dtq_stream_if.source rsp,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata
);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    state_t state_reg, state_next;

    in_word_t   cur_reg, cur_next;
    logic [4:0] max_rel_reg, max_rel_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0] seq_reg, seq_next;
    logic        stopped_reg, stopped_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pidx_reg, pidx_next;

    logic          best_found_reg, best_found_next;
    entry_t        best_reg, best_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;

    logic [4:0]  n_reg, n_next;
    out_word_t   res_reg, res_next;
    logic        again_reg, again_next;
    out_word_t   rsp_reg, rsp_next;
    logic        rsp_v_reg, rsp_v_next;

    logic   ram_we, ram_re;
    entry_t ram_wdata, ram_rdata;
    logic [IW-1:0] ram_raddr;

    logic [32:0] dl_sum;
    logic [31:0] dl;
    logic [4:0]  cap;
    logic        rel_ok;
    logic        better;

    dtq_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = rsp_v_reg;
    assign rsp.payload = rsp_reg;

    assign dl_sum = {1'b0, cur_reg.now_ms} + {1'b0, cur_reg.defer_ms};
    assign dl     = dl_sum[32] ? TIME_MAX : dl_sum[31:0];
    assign rel_ok = (cur_reg.poll_budget_ms != 32'd0) && (cur_reg.now_ms != TIME_MAX);
    assign cap    = (max_rel_reg == 5'd0) ? 5'd1
                  : (max_rel_reg > 5'(MAX_CAP)) ? 5'(MAX_CAP) : max_rel_reg;

    assign better = valid_reg[pidx_reg] &&
                    (!best_found_reg || (ram_rdata.deadline < best_reg.deadline) ||
                     ((ram_rdata.deadline == best_reg.deadline) &&
                      (ram_rdata.sequence_no < best_reg.sequence_no)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && ((req.payload.mode == MODE_SCHED) ||
                                  (req.payload.mode == MODE_POLL)))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((cnt_reg == CW'(QUEUE_DEPTH)) && !pend_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!rsp_v_reg || rsp.ready)
                begin
                    state_next = again_reg ? ST_SCAN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_next        = cur_reg;
        max_rel_next    = cfg_we ? cfg_wdata : max_rel_reg;
        valid_next      = valid_reg;
        seq_next        = seq_reg;
        stopped_next    = stopped_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        best_found_next = best_found_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        n_next          = n_reg;
        res_next        = res_reg;
        again_next      = again_reg;
        rsp_next        = rsp_reg;
        rsp_v_next      = rsp_v_reg && !rsp.ready;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = cnt_reg[IW-1:0];
        ram_wdata       = '{deadline: dl, sequence_no: seq_reg, task_id: cur_reg.task_id};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cur_next        = req.payload;
                    cnt_next        = '0;
                    n_next          = '0;
                    best_found_next = 1'b0;
                    free_found_next = 1'b0;
                    if (req.payload.mode == MODE_STOP)
                    begin
                        valid_next   = '0;
                        stopped_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg < CW'(QUEUE_DEPTH))
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[IW-1:0];
                    cnt_next  = cnt_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    if (better)
                    begin
                        best_found_next = 1'b1;
                        best_next       = ram_rdata;
                        best_idx_next   = pidx_reg;
                    end
                    if (!valid_reg[pidx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pidx_reg;
                    end
                end
            end
            ST_DECIDE:
            begin
                res_next   = '0;
                res_next.last = 1'b1;
                again_next = 1'b0;
                if (cur_reg.mode == MODE_SCHED)
                begin
                    res_next.kind = KIND_SCHED;
                    if (stopped_reg || !free_found_reg)
                    begin
                        res_next.rejected = 1'b1;
                    end
                    else
                    begin
                        ram_we                    = 1'b1;
                        valid_next[free_idx_reg]  = 1'b1;
                        seq_next                  = seq_reg + 32'd1;
                        if (!best_found_reg || (dl < best_reg.deadline))
                        begin
                            res_next.flag     = 1'b1;
                            res_next.delay_ms = cur_reg.defer_ms;
                        end
                    end
                end
                else if (rel_ok && best_found_reg && (best_reg.deadline <= cur_reg.now_ms) &&
                         (n_reg < cap))
                begin
                    res_next.kind            = KIND_RELEASE;
                    res_next.out_task_id     = best_reg.task_id;
                    res_next.last            = 1'b0;
                    valid_next[best_idx_reg] = 1'b0;
                    n_next                   = n_reg + 5'd1;
                    again_next               = 1'b1;
                end
                else
                begin
                    res_next.kind = KIND_SUMMARY;
                    res_next.flag = best_found_reg;
                    if (best_found_reg && (best_reg.deadline > cur_reg.now_ms))
                    begin
                        res_next.delay_ms = best_reg.deadline - cur_reg.now_ms;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!rsp_v_reg || rsp.ready)
                begin
                    rsp_next        = res_reg;
                    rsp_v_next      = 1'b1;
                    cnt_next        = '0;
                    best_found_next = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            max_rel_reg <= 5'(MAX_CAP);
            valid_reg   <= '0;
            seq_reg     <= '0;
            stopped_reg <= 1'b0;
            pend_reg    <= 1'b0;
            rsp_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            max_rel_reg <= max_rel_next;
            valid_reg   <= valid_next;
            seq_reg     <= seq_next;
            stopped_reg <= stopped_next;
            pend_reg    <= pend_next;
            rsp_v_reg   <= rsp_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        cnt_reg        <= cnt_next;
        pidx_reg       <= pidx_next;
        best_found_reg <= best_found_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        n_reg          <= n_next;
        res_reg        <= res_next;
        again_reg      <= again_next;
        rsp_reg        <= rsp_next;
    end
endmodule
`default_nettype wire

### sv/dtq_checker.sv
`default_nettype none
module dtq_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic [1:0]  req_mode,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [1:0]  rsp_kind,
    input wire logic        rsp_flag,
    input wire logic        rsp_rejected,
    input wire logic        rsp_last,
    input wire logic [15:0] rsp_task,
    input wire logic [31:0] rsp_delay
);
    import dtq_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_task)
            && $stable(rsp_delay) && $stable(rsp_last))
        else $error("rsp word changed while stalled");

    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_RELEASE) |-> !rsp_last && !rsp_flag && !rsp_rejected
            && (rsp_delay == 32'd0))
        else $error("released word with bad fields");

    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind != KIND_RELEASE) |-> rsp_last && (rsp_task == 16'd0))
        else $error("answer or summary not marked last");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && ((req_mode == MODE_SCHED) || (req_mode == MODE_POLL))
            |=> !req_ready)
        else $error("req taken while busy");
endmodule

bind deadline_task_queue dtq_checker u_dtq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_mode     (req.payload.mode),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_kind     (rsp.payload.kind),
    .rsp_flag     (rsp.payload.flag),
    .rsp_rejected (rsp.payload.rejected),
    .rsp_last     (rsp.payload.last),
    .rsp_task     (rsp.payload.out_task_id),
    .rsp_delay    (rsp.payload.delay_ms)
);
`default_nettype wire
